// ===== design/twelve_bit_cpu_execute_macros.svh =====
// Assertion macros used by the checker file
`ifndef TWELVE_BIT_CPU_EXECUTE_MACROS_SVH
`define TWELVE_BIT_CPU_EXECUTE_MACROS_SVH
// Implication check, sampled on the rising clock edge, off during reset
`define TBCE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("check failed");
// Next-cycle implication check
`define TBCE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("check failed");
`endif

// ===== design/tbce_pkg.sv =====
// Package: types and constants for the 12-bit processor execute block
`default_nettype none
package tbce_pkg;
  localparam int unsigned MemWordsDef  = 4096;
  localparam int unsigned PageWordsDef = 128;
  localparam int unsigned AddrW        = 12;
  localparam int unsigned WordW        = 12;

  localparam logic [1:0] KindLoad   = 2'd0;
  localparam logic [1:0] KindStart  = 2'd1;
  localparam logic [1:0] KindStep   = 2'd2;
  localparam logic [1:0] KindUnused = 2'd3;

  localparam logic [2:0] OpAnd = 3'd0;
  localparam logic [2:0] OpTad = 3'd1;
  localparam logic [2:0] OpIsz = 3'd2;
  localparam logic [2:0] OpDca = 3'd3;
  localparam logic [2:0] OpJms = 3'd4;
  localparam logic [2:0] OpJmp = 3'd5;
  localparam logic [2:0] OpIot = 3'd6;
  localparam logic [2:0] OpOpr = 3'd7;

  localparam logic [5:0] DevKbd = 6'o03;
  localparam logic [5:0] DevTty = 6'o04;

  localparam logic RegStart    = 1'b0;
  localparam logic RegSwitches = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DECODE,
    ST_IND_RD,
    ST_IND_WAIT,
    ST_AUTO_WR,
    ST_OPER_RD,
    ST_OPER_WAIT,
    ST_EXEC,
    ST_DONE
  } state_e;
endpackage
`default_nettype wire

// ===== design/twelve_bit_cpu_execute.sv =====
// Top level: 12-bit processor with a private word store, one item at a time
// Each item passes through one store port and a shared 12-bit adder. Load and start
// pass through fetch and result; an instruction through fetch, decode, execute and
// result, plus an indirect read and wait, an auto-index write and an operand read and
// wait where it needs them. Each item returns to idle before the next request is
// taken. The store port makes one access per cycle. The store is cleared after reset
// by a pass over all MEM_WORDS words, one word a cycle, during which no item is
// accepted. A result sits in an output register apart from the working registers;
// a finished item waits in its last cycle only while an earlier result is still
// untaken.
`default_nettype none
module twelve_bit_cpu_execute #(
  parameter int unsigned MEM_WORDS  = tbce_pkg::MemWordsDef,
  parameter int unsigned PAGE_WORDS = tbce_pkg::PageWordsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [11:0] load_address_i,
  input  wire logic [11:0] load_word_i,
  input  wire logic [7:0]  key_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [11:0]      program_counter_o,
  output logic [11:0]      accumulator_o,
  output logic             link_bit_o,
  output logic             is_halted_o,
  output logic             print_valid_o,
  output logic [6:0]       print_char_o,
  output logic             key_used_o
);
  localparam int unsigned MemAw = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int unsigned PageAw = $clog2(PAGE_WORDS);

  // configuration registers
  logic [11:0] start_q, sw_q;
  logic        cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 12'o0200;
      sw_q    <= '0;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      if (paddr[2] == tbce_pkg::RegStart) start_q <= pwdata[11:0];
      else                                sw_q    <= pwdata[11:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[2] == tbce_pkg::RegStart) prdata[11:0] = start_q;
      else                                prdata[11:0] = sw_q;
    end
  end

  // clearing pass after reset
  logic [MemAw:0] clr_q;
  logic           clr_busy;
  assign clr_busy = (clr_q < MEM_WORDS[MemAw:0]);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       clr_q <= '0;
    else if (clr_busy) clr_q <= clr_q + 1'b1;
  end

  // architectural state
  tbce_pkg::state_e state_q, state_d;
  logic [11:0] pc_q, ac_q, ir_q, ea_q, md_q, npc_q;
  logic        link_q, halt_q;
  logic [1:0]  kind_q;
  logic [11:0] la_q, lw_q;
  logic [7:0]  key_q;
  logic        ovalid_q;
  logic        pv_q, ku_q;
  logic [6:0]  pch_q;

  // result register
  logic [11:0] opc_q, oac_q;
  logic        olink_q, ohalt_q, opv_q, oku_q;
  logic [6:0]  opch_q;
  logic        out_load;

  // store: one port, registered read data
  logic [11:0] mem [MEM_WORDS];
  logic [11:0] rdata_q;
  logic        m_we;
  logic [11:0] m_addr, m_wdata;
  logic        m_inrange;
  assign m_inrange = ({1'b0, m_addr} < 13'(MEM_WORDS));
  always_ff @(posedge clk_i) begin
    if (clr_busy) begin
      mem[clr_q[MemAw-1:0]] <= '0;
    end else if (m_we && m_inrange) begin
      mem[m_addr[MemAw-1:0]] <= m_wdata;
    end
    rdata_q <= m_inrange ? mem[m_addr[MemAw-1:0]] : '0;
  end

  // shared adder
  logic [11:0] add_a;
  logic        add_b_sel;
  logic [12:0] add_sum;
  assign add_sum = {1'b0, add_a} + (add_b_sel ? {1'b0, md_q} : 13'd1);

  // decode helpers
  logic [2:0]  op;
  logic        ind;
  logic [11:0] dir_addr;
  logic [11:0] page_base;
  assign op  = ir_q[11:9];
  assign ind = ir_q[8] && (op < tbce_pkg::OpIot);
  assign page_base = {pc_q[11:PageAw], {PageAw{1'b0}}};
  assign dir_addr = ir_q[7] ? (page_base | {5'd0, ir_q[6:0]}) : {5'd0, ir_q[6:0]};
  logic auto_ix;
  assign auto_ix = (dir_addr[11:3] == 9'o001);
  logic needs_oper;
  assign needs_oper = (op == tbce_pkg::OpAnd) || (op == tbce_pkg::OpTad) ||
                      (op == tbce_pkg::OpIsz);

  // decode of the word just fetched, while ir_q still holds the old one
  logic [2:0] d_op;
  logic       d_ind, d_needs_oper;
  assign d_op  = rdata_q[11:9];
  assign d_ind = rdata_q[8] && (d_op < tbce_pkg::OpIot);
  assign d_needs_oper = (d_op == tbce_pkg::OpAnd) || (d_op == tbce_pkg::OpTad) ||
                        (d_op == tbce_pkg::OpIsz);

  assign in_ready_o  = (state_q == tbce_pkg::ST_IDLE) && !clr_busy;
  logic acc_in;
  assign acc_in = in_valid_i && in_ready_o;
  assign out_load = (state_q == tbce_pkg::ST_DONE) && (!ovalid_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tbce_pkg::ST_IDLE: if (acc_in) begin
        state_d = tbce_pkg::ST_FETCH;
      end
      tbce_pkg::ST_FETCH: begin
        if (kind_q == tbce_pkg::KindStep && !halt_q) state_d = tbce_pkg::ST_DECODE;
        else                                         state_d = tbce_pkg::ST_DONE;
      end
      tbce_pkg::ST_DECODE: begin
        if (d_ind)                                        state_d = tbce_pkg::ST_IND_RD;
        else if (d_needs_oper)                            state_d = tbce_pkg::ST_OPER_RD;
        else                                              state_d = tbce_pkg::ST_EXEC;
      end
      tbce_pkg::ST_IND_RD: state_d = tbce_pkg::ST_IND_WAIT;
      tbce_pkg::ST_IND_WAIT: begin
        if (auto_ix)         state_d = tbce_pkg::ST_AUTO_WR;
        else if (needs_oper) state_d = tbce_pkg::ST_OPER_RD;
        else                 state_d = tbce_pkg::ST_EXEC;
      end
      tbce_pkg::ST_AUTO_WR: state_d = needs_oper ? tbce_pkg::ST_OPER_RD : tbce_pkg::ST_EXEC;
      tbce_pkg::ST_OPER_RD: state_d = tbce_pkg::ST_OPER_WAIT;
      tbce_pkg::ST_OPER_WAIT: state_d = tbce_pkg::ST_EXEC;
      tbce_pkg::ST_EXEC: state_d = tbce_pkg::ST_DONE;
      tbce_pkg::ST_DONE: state_d = out_load ? tbce_pkg::ST_IDLE : tbce_pkg::ST_DONE;
      default: state_d = tbce_pkg::ST_IDLE;
    endcase
  end

  // store port and adder selection
  always_comb begin
    m_we = 1'b0;
    m_addr = pc_q;
    m_wdata = '0;
    add_a = pc_q;
    add_b_sel = 1'b0;
    unique case (state_q)
      tbce_pkg::ST_IDLE:  m_addr = pc_q;
      tbce_pkg::ST_FETCH: begin
        m_addr = la_q;
        m_wdata = lw_q;
        m_we = (kind_q == tbce_pkg::KindLoad);
        if (kind_q != tbce_pkg::KindLoad) m_addr = pc_q;
      end
      tbce_pkg::ST_DECODE:  add_a = pc_q;
      tbce_pkg::ST_IND_RD:  m_addr = dir_addr;
      tbce_pkg::ST_IND_WAIT: add_a = rdata_q;
      tbce_pkg::ST_AUTO_WR: begin
        m_addr = dir_addr;
        m_wdata = ea_q;
        m_we = 1'b1;
      end
      tbce_pkg::ST_OPER_RD: m_addr = ea_q;
      tbce_pkg::ST_OPER_WAIT: add_a = pc_q;
      tbce_pkg::ST_EXEC: begin
        m_addr = ea_q;
        unique case (op)
          tbce_pkg::OpTad: begin
            add_a = ac_q;
            add_b_sel = 1'b1;
          end
          tbce_pkg::OpIsz: begin
            add_a = md_q;
            m_wdata = add_sum[11:0];
            m_we = 1'b1;
          end
          tbce_pkg::OpDca: begin
            m_wdata = ac_q;
            m_we = 1'b1;
          end
          tbce_pkg::OpJms: begin
            m_wdata = npc_q;
            m_we = 1'b1;
            add_a = ea_q;
          end
          default: add_a = npc_q;
        endcase
      end
      default: m_addr = pc_q;
    endcase
  end

  // group 1 operate and iot/skip evaluation (combinational, narrow)
  logic [11:0] g1_ac;
  logic        g1_l;
  logic [12:0] rot;
  logic [12:0] inc1;
  always_comb begin
    g1_ac = ac_q;
    g1_l  = link_q;
    if (ir_q[7]) g1_ac = '0;
    if (ir_q[6]) g1_l = 1'b0;
    if (ir_q[5]) g1_ac = ~g1_ac;
    if (ir_q[4]) g1_l = ~g1_l;
    inc1 = {1'b0, g1_ac} + 13'd1;
    if (ir_q[0]) begin
      g1_ac = inc1[11:0];
      g1_l  = g1_l ^ inc1[12];
    end
    rot = {g1_l, g1_ac};
    if (ir_q[3]) begin
      rot = {rot[0], rot[12:1]};
      if (ir_q[1]) rot = {rot[0], rot[12:1]};
    end
    if (ir_q[2]) begin
      rot = {rot[11:0], rot[12]};
      if (ir_q[1]) rot = {rot[11:0], rot[12]};
    end
  end
  logic g2_cond;
  assign g2_cond = ((ir_q[6] && ac_q[11]) || (ir_q[5] && ac_q == '0) ||
                    (ir_q[4] && link_q)) ^ ir_q[3];
  logic [5:0] dev;
  assign dev = ir_q[8:3];

  // datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tbce_pkg::ST_IDLE;
      pc_q     <= '0;
      ac_q     <= '0;
      link_q   <= 1'b0;
      halt_q   <= 1'b0;
      pv_q     <= 1'b0;
      ku_q     <= 1'b0;
      pch_q    <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        tbce_pkg::ST_IDLE: begin
          if (acc_in) begin
            pv_q  <= 1'b0;
            ku_q  <= 1'b0;
            pch_q <= '0;
          end
        end
        tbce_pkg::ST_FETCH: begin
          if (kind_q == tbce_pkg::KindStart) begin
            pc_q   <= start_q;
            halt_q <= 1'b0;
          end
        end
        tbce_pkg::ST_EXEC: begin
          pc_q <= npc_q;
          unique case (op)
            tbce_pkg::OpAnd: ac_q <= ac_q & md_q;
            tbce_pkg::OpTad: begin
              ac_q   <= add_sum[11:0];
              link_q <= link_q ^ add_sum[12];
            end
            tbce_pkg::OpIsz: if (add_sum[11:0] == '0) pc_q <= npc_q + 12'd1;
            tbce_pkg::OpDca: ac_q <= '0;
            tbce_pkg::OpJms: pc_q <= add_sum[11:0];
            tbce_pkg::OpJmp: pc_q <= ea_q;
            tbce_pkg::OpIot: begin
              if (dev == tbce_pkg::DevKbd) begin
                if (ir_q[0]) pc_q <= add_sum[11:0];
                if (ir_q[2]) begin
                  ac_q <= {4'd0, key_q};
                  ku_q <= 1'b1;
                end
              end else if (dev == tbce_pkg::DevTty) begin
                if (ir_q[0]) pc_q <= add_sum[11:0];
                if (ir_q[2]) begin
                  pv_q  <= 1'b1;
                  pch_q <= ac_q[6:0];
                end
                if (ir_q[1]) ac_q <= '0;
              end
            end
            default: begin
              if (!ir_q[8]) begin
                ac_q   <= rot[11:0];
                link_q <= rot[12];
              end else begin
                ac_q <= (ir_q[7] ? 12'd0 : ac_q) | (ir_q[2] ? sw_q : 12'd0);
                if (g2_cond) pc_q <= add_sum[11:0];
                if (ir_q[1]) halt_q <= 1'b1;
              end
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  // result register, loaded as an item finishes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      opc_q    <= '0;
      oac_q    <= '0;
      olink_q  <= 1'b0;
      ohalt_q  <= 1'b0;
      opv_q    <= 1'b0;
      opch_q   <= '0;
      oku_q    <= 1'b0;
    end else if (out_load) begin
      ovalid_q <= 1'b1;
      opc_q    <= pc_q;
      oac_q    <= ac_q;
      olink_q  <= link_q;
      ohalt_q  <= halt_q;
      opv_q    <= pv_q;
      opch_q   <= pch_q;
      oku_q    <= ku_q;
    end else if (ovalid_q && out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      kind_q <= kind_i;
      la_q   <= load_address_i;
      lw_q   <= load_word_i;
      key_q  <= key_byte_i;
    end
    unique case (state_q)
      tbce_pkg::ST_DECODE: begin
        ir_q  <= rdata_q;
        ea_q  <= {5'd0, rdata_q[6:0]} |
                 (rdata_q[7] ? {pc_q[11:PageAw], {PageAw{1'b0}}} : 12'd0);
        npc_q <= add_sum[11:0];
      end
      tbce_pkg::ST_IND_WAIT: ea_q <= auto_ix ? add_sum[11:0] : rdata_q;
      tbce_pkg::ST_OPER_WAIT: md_q <= rdata_q;
      default: ;
    endcase
  end

  assign out_valid_o       = ovalid_q;
  assign program_counter_o = opc_q;
  assign accumulator_o     = oac_q;
  assign link_bit_o        = olink_q;
  assign is_halted_o       = ohalt_q;
  assign print_valid_o     = opv_q;
  assign print_char_o      = opch_q;
  assign key_used_o        = oku_q;
endmodule
`default_nettype wire

// ===== design/tbce_checker.sv =====
// Port-level checker for the 12-bit processor execute block, with its bind
`default_nettype none
`include "twelve_bit_cpu_execute_macros.svh"
module tbce_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic       print_valid_o,
  input wire logic [6:0] print_char_o,
  input wire logic       key_used_o,
  input wire logic       is_halted_o
);
  // a waiting result stays offered
  `TBCE_ASSERT_NXT(a_hold_valid, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  // no character without a print
  `TBCE_ASSERT_IMP(a_char_zero, clk_i, rst_ni, out_valid_o && !print_valid_o, print_char_o == 7'd0)
  // the block is busy in the cycle after it takes a request
  `TBCE_ASSERT_NXT(a_ready_drop, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // never both key use and print in one result
  `TBCE_ASSERT_IMP(a_excl, clk_i, rst_ni, out_valid_o, !(key_used_o && print_valid_o))
  // a waiting result keeps its halt flag and character
  `TBCE_ASSERT_NXT(a_hold_data, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(is_halted_o) && $stable(print_char_o))
endmodule
bind twelve_bit_cpu_execute tbce_checker u_tbce_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .print_valid_o(print_valid_o),
  .print_char_o(print_char_o), .key_used_o(key_used_o), .is_halted_o(is_halted_o)
);
`default_nettype wire
